// ===== design/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP matcher.
// Used by kmp_ram users, kmp_ctrl, kmp_datapath and kmp_stream_matcher_core.
package kmp_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int SYM_W       = 8;
	localparam int CNT_W       = 32;
	localparam int OUT_LEN_W   = 7;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 72;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TEXT  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_RD     = 8'b0000_0010,
		S_CMP    = 8'b0000_0100,
		S_LD_FIN = 8'b0000_1000,
		S_TX_END = 8'b0001_0000,
		S_TX_FRD = 8'b0010_0000,
		S_TX_FWB = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic fail_last;
		logic cmp;
		logic ld_fin;
		logic tx_end;
		logic fall_wb;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic plen_zero;
		logic plen_full;
		logic cont;
		logic hit;
		logic op_load;
		logic out_busy;
	} status_t;

endpackage

// ===== design/kmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/kmp_ctrl.sv =====
// Controller state machine of the KMP matcher: sequences load, text and clear items.
// Depends on kmp_pkg; drives the datapath through kmp_pkg::cmd_t.
module kmp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  kmp_pkg::op_t      in_op,
	input  kmp_pkg::status_t  st,
	output logic              in_ready,
	output kmp_pkg::cmd_t     cmd
);

	kmp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == kmp_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			kmp_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (in_op)
						kmp_pkg::OP_LOAD: begin
							if (st.plen_full) begin
								state_d = kmp_pkg::S_DONE;
							end else if (st.plen_zero) begin
								state_d = kmp_pkg::S_LD_FIN;
							end else begin
								state_d = kmp_pkg::S_RD;
							end
						end
						kmp_pkg::OP_TEXT: begin
							state_d = st.plen_zero ? kmp_pkg::S_DONE : kmp_pkg::S_RD;
						end
						default: state_d = kmp_pkg::S_DONE;
					endcase
				end
			end
			kmp_pkg::S_RD: begin
				cmd.rd  = 1'b1;
				state_d = kmp_pkg::S_CMP;
			end
			kmp_pkg::S_CMP: begin
				cmd.cmp = 1'b1;
				if (st.cont) begin
					state_d = kmp_pkg::S_RD;
				end else if (st.op_load) begin
					state_d = kmp_pkg::S_LD_FIN;
				end else begin
					state_d = kmp_pkg::S_TX_END;
				end
			end
			kmp_pkg::S_LD_FIN: begin
				cmd.ld_fin = 1'b1;
				state_d    = kmp_pkg::S_DONE;
			end
			kmp_pkg::S_TX_END: begin
				cmd.tx_end = 1'b1;
				state_d    = st.hit ? kmp_pkg::S_TX_FRD : kmp_pkg::S_DONE;
			end
			kmp_pkg::S_TX_FRD: begin
				cmd.rd        = 1'b1;
				cmd.fail_last = 1'b1;
				state_d       = kmp_pkg::S_TX_FWB;
			end
			kmp_pkg::S_TX_FWB: begin
				cmd.fall_wb = 1'b1;
				state_d     = kmp_pkg::S_DONE;
			end
			kmp_pkg::S_DONE: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = kmp_pkg::S_IDLE;
				end
			end
			default: state_d = kmp_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== design/kmp_datapath.sv =====
// Datapath of the KMP matcher: pattern and failure RAMs, counters, output register.
// Depends on kmp_pkg and kmp_ram; commanded by kmp_ctrl.
module kmp_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kmp_pkg::cmd_t                   cmd,
	input  kmp_pkg::op_t                    in_op,
	input  logic [kmp_pkg::SYM_W-1:0]       in_sym,
	input  logic                            out_ready,
	output kmp_pkg::status_t                st,
	output logic                            out_valid,
	output logic                            out_found,
	output logic [kmp_pkg::OUT_DATA_W-1:0]  out_data
);

	logic [kmp_pkg::LEN_W-1:0] plen_q, bp_q, matched_q, j_q;
	logic [kmp_pkg::CNT_W-1:0] pos_q, count_q, start_q;
	logic [kmp_pkg::SYM_W-1:0] sym_q;
	kmp_pkg::op_t              op_q;
	logic                      hit_q;
	logic                      out_valid_q;

	logic                      pat_we, fail_we;
	logic [kmp_pkg::IDX_W-1:0] pat_raddr, fail_raddr;
	logic [kmp_pkg::SYM_W-1:0] pat_rd;
	logic [kmp_pkg::IDX_W-1:0] fail_rd;
	logic [kmp_pkg::LEN_W-1:0] fail_rd_ext, plen_m1, j_m1;
	logic                      eq;
	logic [kmp_pkg::CNT_W-1:0] plen_wide;

	assign plen_m1     = plen_q - kmp_pkg::LEN_W'(1);
	assign j_m1        = j_q - kmp_pkg::LEN_W'(1);
	assign pat_raddr   = j_q[kmp_pkg::IDX_W-1:0];
	assign fail_raddr  = cmd.fail_last ? plen_m1[kmp_pkg::IDX_W-1:0] : j_m1[kmp_pkg::IDX_W-1:0];
	assign fail_rd_ext = kmp_pkg::LEN_W'(fail_rd);
	assign pat_we      = cmd.accept && (in_op == kmp_pkg::OP_LOAD) && !st.plen_full;
	assign fail_we     = cmd.ld_fin;
	assign eq          = (pat_rd == sym_q);
	assign plen_wide   = kmp_pkg::CNT_W'(plen_q);

	kmp_ram #(
		.WIDTH(kmp_pkg::SYM_W),
		.DEPTH(kmp_pkg::MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(plen_q[kmp_pkg::IDX_W-1:0]),
		.wdata(in_sym),
		.re   (cmd.rd),
		.raddr(pat_raddr),
		.rdata(pat_rd)
	);

	kmp_ram #(
		.WIDTH(kmp_pkg::IDX_W),
		.DEPTH(kmp_pkg::MAX_PATTERN)
	) u_fail_ram (
		.clk  (clk),
		.we   (fail_we),
		.waddr(plen_q[kmp_pkg::IDX_W-1:0]),
		.wdata(j_q[kmp_pkg::IDX_W-1:0]),
		.re   (cmd.rd),
		.raddr(fail_raddr),
		.rdata(fail_rd)
	);

	always_comb begin
		st.plen_zero = (plen_q == '0);
		st.plen_full = (plen_q >= kmp_pkg::LEN_W'(kmp_pkg::MAX_PATTERN));
		st.cont      = (j_q != '0) && !eq;
		st.hit       = (j_q == plen_q);
		st.op_load   = (op_q == kmp_pkg::OP_LOAD);
		st.out_busy  = out_valid_q && !out_ready;
	end

	// Counters and match progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			bp_q      <= '0;
			matched_q <= '0;
			pos_q     <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.accept) begin
				case (in_op)
					kmp_pkg::OP_TEXT: pos_q <= pos_q + kmp_pkg::CNT_W'(1);
					kmp_pkg::OP_CLEAR: begin
						plen_q    <= '0;
						bp_q      <= '0;
						matched_q <= '0;
						pos_q     <= '0;
						count_q   <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.ld_fin) begin
				bp_q      <= j_q;
				plen_q    <= plen_q + kmp_pkg::LEN_W'(1);
				matched_q <= '0;
			end
			if (cmd.tx_end) begin
				if (st.hit) begin
					if (count_q != '1) begin
						count_q <= count_q + kmp_pkg::CNT_W'(1);
					end
				end else begin
					matched_q <= j_q;
				end
			end
			if (cmd.fall_wb) begin
				matched_q <= fail_rd_ext;
			end
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= in_op;
			sym_q <= in_sym;
			hit_q <= 1'b0;
			if (in_op == kmp_pkg::OP_LOAD) begin
				j_q <= st.plen_zero ? '0 : bp_q;
			end else begin
				j_q <= (matched_q >= plen_q) ? '0 : matched_q;
			end
		end
		if (cmd.cmp) begin
			if (st.cont) begin
				j_q <= fail_rd_ext;
			end else if (eq) begin
				j_q <= j_q + kmp_pkg::LEN_W'(1);
			end
		end
		if (cmd.tx_end && st.hit) begin
			hit_q   <= 1'b1;
			start_q <= pos_q - plen_wide;
		end
	end

	// Output register; the next item may start while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_found <= hit_q;
			out_data  <= {1'b0, plen_wide[kmp_pkg::OUT_LEN_W-1:0], count_q,
				hit_q ? start_q : '0};
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/kmp_stream_matcher_core.sv =====
// Top level of the streaming KMP matcher: stream ports, controller and datapath.
// Depends on kmp_pkg, kmp_ctrl, kmp_datapath (and kmp_ram below it).
//
//  channel | direction | tuser                  | tdata (lowest bit up)
//  s_*     | in        | [1:0] op               | [7:0] symbol
//  m_*     | out       | [0] found              | [31:0] match_start, [63:32] match_total,
//          |           |                        | [70:64] loaded_length, [71] zero
//
// One item is worked on at a time. Clear, ignored and empty-pattern text items and loads
// into a full pattern go from S_IDLE to S_DONE, the first load via S_LD_FIN, and any other
// load or text byte via S_RD and S_CMP, again per failure-chain step, then S_LD_FIN or
// S_TX_END (with S_TX_FRD and S_TX_FWB on a match) to S_DONE. Each step is one read of the
// pattern and failure RAMs followed by one compare. Reset clears the counters and the
// pattern length; the RAMs need no clearing. S_DONE repeats while the previous result still
// waits on m_tready; a waiting result does not hold back the acceptance of the next item.
module kmp_stream_matcher_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kmp_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] symbol
	input  logic [1:0]                      s_tuser,   // [1:0] op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kmp_pkg::OUT_DATA_W-1:0]  m_tdata,   // match_start, match_total, loaded_length
	output logic                            m_tuser    // [0] found
);

	kmp_pkg::cmd_t    cmd;
	kmp_pkg::status_t st;
	kmp_pkg::op_t     in_op;

	assign in_op = kmp_pkg::op_t'(s_tuser);

	kmp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_op   (in_op),
		.st      (st),
		.in_ready(s_tready),
		.cmd     (cmd)
	);

	kmp_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_op    (in_op),
		.in_sym   (s_tdata[kmp_pkg::SYM_W-1:0]),
		.out_ready(m_tready),
		.st       (st),
		.out_valid(m_tvalid),
		.out_found(m_tuser),
		.out_data (m_tdata)
	);

	// After an item is taken, the input is not ready again in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after an accept");

	// A reported match implies a nonzero match total.
	a_found_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[63:32] != 32'd0)
		else $error("match reported with zero total");

	// A reported match implies a loaded pattern.
	a_found_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[70:64] != 7'd0)
		else $error("match reported with empty pattern");

	// A result is only produced when no earlier result is still waiting on m_tready.
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(m_tvalid && !m_tready))
		else $error("result overwrote a waiting result");

endmodule

// ===== dv/kmp_stream_matcher_core_tb.sv =====
// Testbench for kmp_stream_matcher_core: directed table then random pattern/text sequences,
// each result checked against its typed row or a KMP predictor; depends on kmp_pkg and RTL.
// Self-checking, no files or arguments; random values follow the simulator seed.
module kmp_stream_matcher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL   = 1100;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic        found;
		logic [31:0] start;
		logic [31:0] total;
		logic [6:0]  loaded;
	} kmp_result_t;

	typedef struct packed {
		kmp_pkg::op_t op;
		logic [7:0]   sym;
		logic         typed;
		kmp_result_t  want;
	} stim_row_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [kmp_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic [1:0]                     s_tuser  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [kmp_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;

	// Predictor state.
	logic [7:0]  pat_mem    [kmp_pkg::MAX_PATTERN];
	logic [6:0]  border_tab [kmp_pkg::MAX_PATTERN];
	int unsigned pat_len    = 0;
	int unsigned border_len = 0;
	int unsigned match_len  = 0;
	logic [31:0] text_pos   = '0;
	logic [31:0] hit_count  = '0;

	kmp_result_t awaited_results[$];
	int          items_sent     = 0;
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	bit          calm           = 1'b0;

	// Rows with typed results can be read straight off the KMP rules; the rest use the predictor.
	stim_row_t directed_rows [23] = '{
		'{kmp_pkg::OP_TEXT,  8'h41, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd0}},
		'{kmp_pkg::OP_NONE,  8'hFF, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd0}},
		'{kmp_pkg::OP_CLEAR, 8'h00, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd0}},
		'{kmp_pkg::OP_LOAD,  8'h00, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd1}},
		'{kmp_pkg::OP_LOAD,  8'h00, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd2}},
		'{kmp_pkg::OP_TEXT,  8'h00, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd2}},
		'{kmp_pkg::OP_TEXT,  8'h00, 1'b1, '{1'b1, 32'd0, 32'd1, 7'd2}},
		'{kmp_pkg::OP_TEXT,  8'h00, 1'b1, '{1'b1, 32'd1, 32'd2, 7'd2}},
		'{kmp_pkg::OP_NONE,  8'h00, 1'b1, '{1'b0, 32'd0, 32'd2, 7'd2}},
		'{kmp_pkg::OP_LOAD,  8'hFF, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h00, 1'b0, '0},
		'{kmp_pkg::OP_CLEAR, 8'hFF, 1'b1, '{1'b0, 32'd0, 32'd0, 7'd0}},
		'{kmp_pkg::OP_LOAD,  8'h41, 1'b0, '0},
		'{kmp_pkg::OP_LOAD,  8'h42, 1'b0, '0},
		'{kmp_pkg::OP_LOAD,  8'h41, 1'b0, '0},
		'{kmp_pkg::OP_LOAD,  8'h42, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h41, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h42, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h41, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h42, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h41, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'h42, 1'b0, '0},
		'{kmp_pkg::OP_TEXT,  8'hFF, 1'b0, '0}
	};

	kmp_stream_matcher_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Advances the predicted matcher by one item and returns the result it must produce.
	function automatic kmp_result_t match_step(input kmp_pkg::op_t op, input logic [7:0] sym);
		kmp_result_t r;
		int unsigned k;
		logic [31:0] pos;
		r = '0;
		case (op)
			kmp_pkg::OP_LOAD: begin
				if (pat_len < kmp_pkg::MAX_PATTERN) begin
					pat_mem[pat_len] = sym;
					if (pat_len == 0) begin
						border_tab[0] = '0;
						border_len = 0;
					end else begin
						k = border_len;
						while (k > 0 && pat_mem[k] != sym)
							k = border_tab[k-1];
						if (pat_mem[k] == sym)
							k++;
						border_tab[pat_len] = 7'(k);
						border_len = k;
					end
					pat_len++;
					match_len = 0;
				end
			end
			kmp_pkg::OP_TEXT: begin
				pos = text_pos;
				text_pos = pos + 32'd1;
				if (pat_len != 0) begin
					k = (match_len >= pat_len) ? 0 : match_len;
					while (k > 0 && pat_mem[k] != sym)
						k = border_tab[k-1];
					if (pat_mem[k] == sym)
						k++;
					if (k == pat_len) begin
						r.found = 1'b1;
						r.start = pos + 32'd1 - 32'(pat_len);
						if (hit_count != '1)
							hit_count++;
						k = border_tab[k-1];
					end
					match_len = k;
				end
			end
			kmp_pkg::OP_CLEAR: begin
				pat_len = 0;
				border_len = 0;
				match_len = 0;
				text_pos = '0;
				hit_count = '0;
			end
			default: ;
		endcase
		r.total = hit_count;
		r.loaded = 7'(pat_len);
		return r;
	endfunction

	task automatic drive_item(input kmp_pkg::op_t op, input logic [7:0] sym, input bit typed,
			input kmp_result_t want);
		kmp_result_t r;
		calm = (items_sent >= 300 && items_sent < 480);
		if (!calm && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= sym;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = match_step(op, sym);
		awaited_results = {awaited_results, (typed ? want : r)};
		items_sent++;
	endtask

	// Holds the input back until every outstanding result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// A well-formed run: optional clear, a pattern over a small alphabet, then text that
	// often repeats the pattern so that overlapping occurrences and failure chains show up.
	task automatic pattern_sequence();
		logic [7:0] alpha [3];
		logic [7:0] pat_bytes [$];
		logic [7:0] b;
		int alpha_n;
		int plen_pick;
		int text_goal;
		int emitted;
		int roll;
		alpha_n = $urandom_range(1, 3);
		foreach (alpha[i])
			alpha[i] = 8'($urandom_range(255));
		if ($urandom_range(3) != 0)
			drive_item(kmp_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
		roll = $urandom_range(99);
		if (roll < 4)
			plen_pick = kmp_pkg::MAX_PATTERN + $urandom_range(0, 3);
		else if (roll < 12)
			plen_pick = $urandom_range(7, 20);
		else
			plen_pick = $urandom_range(1, 6);
		repeat (plen_pick) begin
			b = alpha[$urandom_range(alpha_n - 1)];
			drive_item(kmp_pkg::OP_LOAD, b, 1'b0, '0);
			if (pat_bytes.size() < kmp_pkg::MAX_PATTERN)
				pat_bytes = {pat_bytes, b};
		end
		text_goal = (plen_pick > 20) ? $urandom_range(70, 140) : $urandom_range(8, 30);
		emitted = 0;
		while (emitted < text_goal) begin
			roll = $urandom_range(99);
			if (roll < 20) begin
				foreach (pat_bytes[i])
					drive_item(kmp_pkg::OP_TEXT, pat_bytes[i], 1'b0, '0);
				emitted += pat_bytes.size();
			end else if (roll < 23) begin
				b = alpha[$urandom_range(alpha_n - 1)];
				drive_item(kmp_pkg::OP_LOAD, b, 1'b0, '0);
				if (pat_bytes.size() < kmp_pkg::MAX_PATTERN)
					pat_bytes = {pat_bytes, b};
				emitted++;
			end else if (roll < 26) begin
				drive_item(kmp_pkg::OP_NONE, 8'($urandom_range(255)), 1'b0, '0);
				emitted++;
			end else if (roll < 30) begin
				drive_item(kmp_pkg::OP_TEXT, 8'($urandom_range(255)), 1'b0, '0);
				emitted++;
			end else begin
				drive_item(kmp_pkg::OP_TEXT, alpha[$urandom_range(alpha_n - 1)], 1'b0, '0);
				emitted++;
			end
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(5, 20))
			drive_item(kmp_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
	endtask

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 19);

	// A result arriving with nothing outstanding is a failure on its own.
	always @(posedge clk) begin
		kmp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with no item outstanding", $realtime);
			end else begin
				want = awaited_results.pop_front();
				if ($isunknown(m_tdata) || m_tuser !== want.found
						|| m_tdata[31:0] !== want.start || m_tdata[63:32] !== want.total
						|| m_tdata[70:64] !== want.loaded || m_tdata[71] !== 1'b0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: result mismatch: expected found=%0b start=%0d total=%0d len=%0d",
							$realtime, want.found, want.start, want.total, want.loaded);
						$display("    got found=%0b start=%0d total=%0d len=%0d pad=%0b",
							m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[70:64],
							m_tdata[71]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i])
			drive_item(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].typed,
				directed_rows[i].want);
		drain_results();
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(99) < 70)
				pattern_sequence();
			else
				noise_burst();
			if ($urandom_range(7) == 0)
				drain_results();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
